/* src/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared widths, codes and types of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int SLOTS_DEF = 32;

   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 16;
   localparam int COUNT_W  = 6;
   localparam int OP_W     = 2;
   localparam int INDEX_W  = 5;
   localparam int STATUS_W = 2;

   // rounded slot size needs one more bit than the register (65535 -> 65536)
   localparam int DIV_W = SIZE_W + 1;

   localparam logic [DIV_W-1:0] SIZE_ALIGN_MASK = ~DIV_W'(3);
   localparam logic [DIV_W-1:0] SIZE_MIN        = DIV_W'(4);

   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_RECLAIM = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      REG_BASE_ADDRESS = 2'd0,
      REG_SLOT_SIZE    = 2'd1,
      REG_SLOT_COUNT   = 2'd2
   } reg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

/* src/bsa_req_if.sv */
// ----------------------------------------------------------------------------
// bsa_req_if
// Request channel: one allocator operation per beat.
// ----------------------------------------------------------------------------
interface bsa_req_if;
   logic                         valid;
   logic                         ready;
   logic [bsa_pkg::OP_W-1:0]     operation;
   logic [bsa_pkg::ADDR_W-1:0]   release_address;

   modport source (output valid, output operation, output release_address, input ready);
   modport sink   (input valid, input operation, input release_address, output ready);
endinterface

/* src/bsa_rsp_if.sv */
// ----------------------------------------------------------------------------
// bsa_rsp_if
// Response channel: one result beat per request.
// ----------------------------------------------------------------------------
interface bsa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [bsa_pkg::ADDR_W-1:0]     slot_address;
   logic [bsa_pkg::INDEX_W-1:0]    slot_index;
   logic [bsa_pkg::STATUS_W-1:0]   status;
   logic [bsa_pkg::COUNT_W-1:0]    free_slots;

   modport source (output valid, output slot_address, output slot_index, output status,
                   output free_slots, input ready);
   modport sink   (input valid, input slot_address, input slot_index, input status,
                   input free_slots, output ready);
endinterface

/* src/bsa_divider.sv */
// ----------------------------------------------------------------------------
// bsa_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bsa_divider #(
   parameter int NUM_W = bsa_pkg::ADDR_W,
   parameter int DEN_W = bsa_pkg::DIV_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [NUM_W-1:0]      dividend,
   input  logic [DEN_W-1:0]      divisor,
   output bsa_pkg::div_stat_type stat,
   output logic [NUM_W-1:0]      quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0]    rem_sh;
   logic [DEN_W:0]    diff;
   logic              ge;

   assign rem_sh = {rem_ff, quo_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // partial remainder stays below the divisor, so it fits DEN_W bits
         rem_in  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

/* src/bitmap_slot_allocator_unit.sv */
// ----------------------------------------------------------------------------
// bitmap_slot_allocator_unit
// Fixed-block pool allocator with a free bitmap of up to 32 slots.
// ----------------------------------------------------------------------------
// One request at a time. An allocate steps through idle (lowest free slot),
// multiply (index * size) and done (base + product); a reclaim or unused
// operation goes from idle straight to done; a release waits in the divide
// state for the radix-2 divider that turns (address - base) into a slot index
// one quotient bit per cycle. The result sits in an output register, so the
// next request is taken while the previous result waits. Any register write
// frees every configured slot; write registers only while no request is open.
// ----------------------------------------------------------------------------
module bitmap_slot_allocator_unit #(
   parameter int SLOTS = bsa_pkg::SLOTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   bsa_req_if.sink                      req_ch,
   bsa_rsp_if.source                    rsp_ch,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bsa_pkg::PADDR_W-1:0]  paddr,
   input  logic [bsa_pkg::PDATA_W-1:0]  pwdata,
   output logic [bsa_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);

   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);
   localparam int PROD_W = IDX_W + bsa_pkg::DIV_W;

   localparam int SLOTS_RESET = 32;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MULT   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   function automatic logic [SLOTS-1:0] pool_mask(input logic [bsa_pkg::COUNT_W-1:0] c);
      logic [SLOTS-1:0] m;
      for (int i = 0; i < SLOTS; i++) begin
         m[i] = bsa_pkg::COUNT_W'(i) < c;
      end
      return m;
   endfunction

   function automatic logic [CNT_W-1:0] eff_count(input logic [bsa_pkg::COUNT_W-1:0] c);
      return (c > bsa_pkg::COUNT_W'(SLOTS)) ? CNT_W'(SLOTS) : c[CNT_W-1:0];
   endfunction

   // configuration registers
   logic [bsa_pkg::ADDR_W-1:0]  base_ff, base_in;
   logic [bsa_pkg::SIZE_W-1:0]  size_ff, size_in;
   logic [bsa_pkg::COUNT_W-1:0] count_ff, count_in;

   // pool state
   logic [SLOTS-1:0] map_ff, map_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // sequencer
   state_type                  state_ff, state_in;
   logic [bsa_pkg::OP_W-1:0]   op_ff, op_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bsa_pkg::ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [bsa_pkg::INDEX_W-1:0]   rsp_index_ff, rsp_index_in;
   logic [bsa_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [bsa_pkg::COUNT_W-1:0]   rsp_free_ff, rsp_free_in;

   logic                  cfg_wr;
   bsa_pkg::reg_type      cfg_reg;
   logic                  reinit;
   logic [bsa_pkg::DIV_W-1:0] size_rnd;
   logic [bsa_pkg::DIV_W-1:0] size_eff;
   logic [CNT_W-1:0]      cnt_eff;
   logic [IDX_W-1:0]      low_idx;
   logic                  req_beat;
   logic                  div_start;
   bsa_pkg::div_stat_type div_stat;
   logic [bsa_pkg::ADDR_W-1:0] quotient;
   logic                  in_range;
   logic [SLOTS-1:0]      rel_bit;
   logic                  out_free;

   assign cfg_wr  = psel & penable & pwrite;
   assign cfg_reg = bsa_pkg::reg_type'(paddr[bsa_pkg::PADDR_W-1:2]);
   assign pready  = 1'b1;

   always_comb begin
      case (cfg_reg)
         bsa_pkg::REG_BASE_ADDRESS: prdata = base_ff;
         bsa_pkg::REG_SLOT_SIZE:    prdata = bsa_pkg::PDATA_W'(size_ff);
         bsa_pkg::REG_SLOT_COUNT:   prdata = bsa_pkg::PDATA_W'(count_ff);
         default:                   prdata = '0;
      endcase
   end

   always_comb begin
      base_in  = base_ff;
      size_in  = size_ff;
      count_in = count_ff;
      reinit   = 1'b0;
      if (cfg_wr) begin
         case (cfg_reg)
            bsa_pkg::REG_BASE_ADDRESS: begin
               base_in = pwdata;
               reinit  = 1'b1;
            end
            bsa_pkg::REG_SLOT_SIZE: begin
               size_in = pwdata[bsa_pkg::SIZE_W-1:0];
               reinit  = 1'b1;
            end
            bsa_pkg::REG_SLOT_COUNT: begin
               count_in = pwdata[bsa_pkg::COUNT_W-1:0];
               reinit   = 1'b1;
            end
            default: reinit = 1'b0;
         endcase
      end
   end

   // slot size rounded up to a multiple of four; zero counts as four
   assign size_rnd = ({1'b0, size_ff} + bsa_pkg::DIV_W'(3)) & bsa_pkg::SIZE_ALIGN_MASK;
   assign size_eff = (size_rnd == '0) ? bsa_pkg::SIZE_MIN : size_rnd;
   assign cnt_eff  = eff_count(count_ff);

   always_comb begin
      low_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (map_ff[i]) begin
            low_idx = IDX_W'(i);
         end
      end
   end

   assign req_beat  = req_ch.valid & req_ch.ready;
   assign div_start = req_beat & (req_ch.operation == bsa_pkg::OP_RELEASE);

   bsa_divider #(
      .NUM_W (bsa_pkg::ADDR_W),
      .DEN_W (bsa_pkg::DIV_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_ch.release_address - base_ff),
      .divisor  (size_eff),
      .stat     (div_stat),
      .quotient (quotient)
   );

   assign in_range = quotient < bsa_pkg::ADDR_W'(cnt_eff);
   assign rel_bit  = {{(SLOTS-1){1'b0}}, 1'b1} << quotient[IDX_W-1:0];
   assign out_free = ~rsp_valid_ff | rsp_ch.ready;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      prod_in       = prod_ff;
      map_in        = map_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ch.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_free_in   = rsp_free_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               op_in  = req_ch.operation;
               idx_in = low_idx;
               case (req_ch.operation)
                  bsa_pkg::OP_ALLOC:   state_in = ST_MULT;
                  bsa_pkg::OP_RELEASE: state_in = ST_DIVIDE;
                  default:             state_in = ST_DONE;
               endcase
            end
         end
         ST_MULT: begin
            prod_in  = PROD_W'(idx_ff) * PROD_W'(size_eff);
            state_in = ST_DONE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in      = ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = '0;
               rsp_index_in  = '0;
               rsp_status_in = bsa_pkg::STATUS_OK;
               case (op_ff)
                  bsa_pkg::OP_ALLOC: begin
                     if (map_ff == '0) begin
                        rsp_status_in = bsa_pkg::STATUS_EMPTY;
                     end else begin
                        rsp_addr_in  = base_ff + bsa_pkg::ADDR_W'(prod_ff);
                        rsp_index_in = bsa_pkg::INDEX_W'(idx_ff);
                        map_in       = map_ff & (map_ff - SLOTS'(1));
                        cnt_in       = cnt_ff - CNT_W'(1);
                     end
                  end
                  bsa_pkg::OP_RELEASE: begin
                     if (!in_range) begin
                        rsp_status_in = bsa_pkg::STATUS_RANGE;
                     end else begin
                        rsp_index_in = bsa_pkg::INDEX_W'(quotient[IDX_W-1:0]);
                        map_in       = map_ff | rel_bit;
                        // double release leaves the count alone
                        if ((map_ff & rel_bit) == '0) begin
                           cnt_in = cnt_ff + CNT_W'(1);
                        end
                     end
                  end
                  bsa_pkg::OP_RECLAIM: begin
                     map_in = pool_mask(count_ff);
                     cnt_in = cnt_eff;
                  end
                  default: begin
                     map_in = map_ff;
                  end
               endcase
               rsp_free_in = bsa_pkg::COUNT_W'(cnt_in);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (reinit) begin
         map_in = pool_mask(count_in);
         cnt_in = eff_count(count_in);
      end
   end

   assign req_ch.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      idx_ff        <= idx_in;
      prod_ff       <= prod_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_free_ff   <= rsp_free_in;
      if (reset) begin
         base_ff      <= '0;
         size_ff      <= bsa_pkg::SIZE_W'(4);
         count_ff     <= bsa_pkg::COUNT_W'(SLOTS_RESET);
         map_ff       <= '1;
         cnt_ff       <= CNT_W'(SLOTS);
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         size_ff      <= size_in;
         count_ff     <= count_in;
         map_ff       <= map_in;
         cnt_ff       <= cnt_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.slot_address = rsp_addr_ff;
   assign rsp_ch.slot_index   = rsp_index_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.free_slots   = rsp_free_ff;

   // free count tracks the bitmap
   a_count_matches_map: assert property (@(posedge clock) disable iff (reset)
      $countones(map_ff) == int'(cnt_ff))
      else $error("free count out of step with bitmap");

   // no free bit above the configured slot count
   a_map_in_pool: assert property (@(posedge clock) disable iff (reset)
      (map_ff & ~pool_mask(count_ff)) == '0)
      else $error("free bit set outside the pool");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= cnt_eff)
      else $error("free count above slot count");

   a_beat_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> state_ff != ST_IDLE)
      else $error("request beat did not start the sequencer");

   a_div_only_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ST_DIVIDE)
      else $error("divider running outside release");

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the slot allocator with a directed table, then random traffic of
// all four operations over a series of pool setups. Each request beat is
// predicted by a bitmap model of the pool, and each response beat is compared
// field by field against the oldest prediction. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
   import bsa_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 40;
   localparam int PHASES         = 14;
   localparam int PHASE_ITEMS    = 125;
   localparam int DIRECTED_ROWS  = 35;

   typedef struct packed {
      logic [ADDR_W-1:0]  slot_address;
      logic [INDEX_W-1:0] slot_index;
      status_type         status;
      logic [COUNT_W-1:0] free_slots;
   } slot_result_type;

   typedef enum logic {
      ROW_OP,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [OP_W-1:0]   operation;
      reg_type           target;
      logic [ADDR_W-1:0] value;
      logic              typed;
      slot_result_type   result;
   } directed_row_type;

   localparam slot_result_type NO_RESULT = '0;

   logic               clock;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   bsa_req_if req_bus ();
   bsa_rsp_if rsp_bus ();

   bitmap_slot_allocator_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // pool model state
   logic [ADDR_W-1:0]  pool_base;
   logic [SIZE_W-1:0]  pool_size_reg;
   logic [COUNT_W-1:0] pool_count_reg;
   logic [31:0]        free_map;

   slot_result_type outstanding_results [$];
   slot_result_type awaited;
   int           mismatch_count = 0;
   int           idle_cycles = 0;
   int           stall_left = 0;
   bit           source_gaps = 1'b1;
   bit           sink_stalls = 1'b1;

   logic [SIZE_W-1:0]  size_picks [7] = '{16'd4, 16'd0, 16'hFFFF, 16'd1, 16'd3, 16'hFFFC, 16'd5};
   logic [COUNT_W-1:0] count_picks [7] = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd33, 6'd2, 6'd31};

   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // fresh pool: base 0, 4-byte slots, 32 slots
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_OK, 6'd31}},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0004, 5'd1, STATUS_OK, 6'd30}},
      // address in the middle of a slot
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'h0000_0006, 1'b1,
        '{32'h0000_0000, 5'd1, STATUS_OK, 6'd31}},
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_OK, 6'd32}},
      // slot already free
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_OK, 6'd32}},
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'hFFFF_FFFF, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_RANGE, 6'd32}},
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'h0000_0080, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_RANGE, 6'd32}},
      '{ROW_OP, OP_UNUSED, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_OK, 6'd32}},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_OK, 6'd31}},
      '{ROW_OP, OP_RECLAIM, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_OK, 6'd32}},
      // single-slot pool runs dry
      '{ROW_CSR, OP_ALLOC, REG_SLOT_COUNT, 32'd1, 1'b0, NO_RESULT},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_OK, 6'd0}},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_EMPTY, 6'd0}},
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'h0000_0004, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_RANGE, 6'd0}},
      '{ROW_OP, OP_RECLAIM, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_OK, 6'd1}},
      // pool with no slots at all
      '{ROW_CSR, OP_ALLOC, REG_SLOT_COUNT, 32'd0, 1'b0, NO_RESULT},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_EMPTY, 6'd0}},
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'h0000_0000, 1'b1,
        '{32'h0000_0000, 5'd0, STATUS_RANGE, 6'd0}},
      // oversized count, zero size, base near the top of memory
      '{ROW_CSR, OP_ALLOC, REG_SLOT_COUNT, 32'd63, 1'b0, NO_RESULT},
      '{ROW_CSR, OP_ALLOC, REG_SLOT_SIZE, 32'd0, 1'b0, NO_RESULT},
      '{ROW_CSR, OP_ALLOC, REG_BASE_ADDRESS, 32'hFFFF_FFF0, 1'b0, NO_RESULT},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'hFFFF_FFEF, 1'b0, NO_RESULT},
      // largest slot size rounds past 16 bits
      '{ROW_CSR, OP_ALLOC, REG_SLOT_SIZE, 32'h0000_FFFF, 1'b0, NO_RESULT},
      '{ROW_CSR, OP_ALLOC, REG_BASE_ADDRESS, 32'h8000_0000, 1'b0, NO_RESULT},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'h8001_FFFF, 1'b0, NO_RESULT},
      // unaligned size rounds up
      '{ROW_CSR, OP_ALLOC, REG_SLOT_SIZE, 32'd5, 1'b0, NO_RESULT},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_OP, OP_ALLOC, REG_BASE_ADDRESS, 32'h0000_0000, 1'b0, NO_RESULT},
      '{ROW_OP, OP_RELEASE, REG_BASE_ADDRESS, 32'h8000_0007, 1'b0, NO_RESULT},
      '{ROW_OP, OP_UNUSED, REG_BASE_ADDRESS, 32'hFFFF_FFFF, 1'b0, NO_RESULT}
   };

   function automatic logic [31:0] slot_bytes();
      logic [SIZE_W:0] rounded;
      rounded = ({1'b0, pool_size_reg} + 17'd3) & ~17'd3;
      return (rounded == '0) ? 32'd4 : 32'(rounded);
   endfunction

   function automatic int pool_slots();
      return (pool_count_reg > 6'd32) ? 32 : int'(pool_count_reg);
   endfunction

   function automatic logic [31:0] pool_mask();
      int c;
      c = pool_slots();
      return (c >= 32) ? 32'hFFFF_FFFF : ((32'd1 << c) - 32'd1);
   endfunction

   function automatic slot_result_type pool_step(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
      slot_result_type res;
      logic [31:0]  slot_no;
      res = NO_RESULT;
      free_map &= pool_mask();
      case (op)
         OP_ALLOC: begin
            if (free_map == '0) begin
               res.status = STATUS_EMPTY;
            end else begin
               // walk down so the lowest free slot wins
               for (int i = 31; i >= 0; i--) begin
                  if (free_map[i]) res.slot_index = INDEX_W'(i);
               end
               free_map[res.slot_index] = 1'b0;
               res.slot_address = pool_base + 32'(res.slot_index) * slot_bytes();
            end
         end
         OP_RELEASE: begin
            slot_no = (addr - pool_base) / slot_bytes();
            if (slot_no >= 32'(pool_slots())) begin
               res.status = STATUS_RANGE;
            end else begin
               free_map[slot_no[4:0]] = 1'b1;
               res.slot_index = slot_no[4:0];
            end
         end
         OP_RECLAIM: begin
            free_map = pool_mask();
         end
         default: ;
      endcase
      res.free_slots = COUNT_W'($countones(free_map));
      return res;
   endfunction

   function automatic int pick_gap();
      return ($urandom_range(0, 9) < 8) ? int'($urandom_range(1, 3)) : int'($urandom_range(8, 40));
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
      end
   endtask

   task automatic send_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                            output slot_result_type predicted);
      req_bus.valid           <= 1'b1;
      req_bus.operation       <= op;
      req_bus.release_address <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = pool_step(op, addr);
   endtask

   task automatic source_gap();
      if (source_gaps && $urandom_range(0, 2) == 0) begin
         req_bus.valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (outstanding_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write, then read the register back in a back-to-back transfer
   task automatic csr_write(input reg_type target, input logic [31:0] value);
      logic [31:0] kept;
      case (target)
         REG_BASE_ADDRESS: kept = value;
         REG_SLOT_SIZE:    kept = {16'd0, value[SIZE_W-1:0]};
         default:          kept = {26'd0, value[COUNT_W-1:0]};
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PADDR_W'({target, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (target)
         REG_BASE_ADDRESS: pool_base = value;
         REG_SLOT_SIZE:    pool_size_reg = value[SIZE_W-1:0];
         default:          pool_count_reg = value[COUNT_W-1:0];
      endcase
      free_map = pool_mask();
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      check_field($sformatf("readback of %s", target.name()), prdata, kept);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // response side backpressure
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (sink_stalls && $urandom_range(0, 3) == 0) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (outstanding_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing open, address %0h",
                                      rsp_bus.slot_address));
         end else begin
            awaited = outstanding_results.pop_front();
            check_field("slot_address", rsp_bus.slot_address, awaited.slot_address);
            check_field("slot_index", 32'(rsp_bus.slot_index), 32'(awaited.slot_index));
            check_field("status", 32'(rsp_bus.status), 32'(awaited.status));
            check_field("free_slots", 32'(rsp_bus.free_slots), 32'(awaited.free_slots));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || psel || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] no beat for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      directed_row_type  row;
      slot_result_type   predicted;
      logic [OP_W-1:0]   op;
      logic [ADDR_W-1:0] addr;
      logic [31:0]       busy_map;
      logic [31:0]       size;
      int                alloc_pct;
      int                pick;
      int                idx;
      int                c;

      reset                   <= 1'b1;
      psel                    <= 1'b0;
      penable                 <= 1'b0;
      pwrite                  <= 1'b0;
      paddr                   <= '0;
      pwdata                  <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.operation       <= OP_ALLOC;
      req_bus.release_address <= '0;
      pool_base      = '0;
      pool_size_reg  = 16'd4;
      pool_count_reg = 6'd32;
      free_map       = pool_mask();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         if (row.kind == ROW_CSR) begin
            wait_for_results();
            csr_write(row.target, row.value);
         end else begin
            send_item(row.operation, row.value, predicted);
            outstanding_results.push_back(row.typed ? row.result : predicted);
            source_gap();
         end
      end

      for (int p = 0; p < PHASES; p++) begin
         source_gaps = (p % 4) != 3;
         sink_stalls = (p % 4) != 3 && (p % 4) != 1;
         wait_for_results();
         case (p % 3)
            0:       csr_write(REG_BASE_ADDRESS, 32'h0000_0000);
            1:       csr_write(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
            default: csr_write(REG_BASE_ADDRESS, $urandom);
         endcase
         if (p < 7) begin
            csr_write(REG_SLOT_SIZE, 32'(size_picks[p]));
            csr_write(REG_SLOT_COUNT, 32'(count_picks[p]));
         end else begin
            csr_write(REG_SLOT_SIZE, ($urandom_range(0, 9) == 0) ?
                      $urandom_range(0, 65535) : $urandom_range(1, 64));
            csr_write(REG_SLOT_COUNT, ($urandom_range(0, 9) == 0) ?
                      $urandom_range(0, 63) : $urandom_range(1, 32));
         end
         alloc_pct = $urandom_range(35, 70);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            c        = pool_slots();
            size     = slot_bytes();
            busy_map = ~free_map & pool_mask();
            pick     = $urandom_range(0, 99);
            addr     = $urandom;
            if (pick < alloc_pct) begin
               op = OP_ALLOC;
            end else if (pick < 94) begin
               op = OP_RELEASE;
               if (pick < 88 && busy_map != '0) begin
                  // hand back a slot that is really held, anywhere inside it
                  do idx = $urandom_range(0, c - 1); while (!busy_map[idx]);
                  addr = pool_base + 32'(idx) * size + $urandom_range(0, size - 1);
               end else begin
                  case ($urandom_range(0, 3))
                     0: addr = $urandom;
                     1: addr = pool_base + 32'($urandom_range(c, c + 2)) * size +
                               $urandom_range(0, size - 1);
                     2: addr = pool_base - $urandom_range(1, 64);
                     default: addr = pool_base + 32'($urandom_range(0, 31)) * size;
                  endcase
               end
            end else if (pick < 97) begin
               op = OP_RECLAIM;
            end else begin
               op = OP_UNUSED;
            end
            send_item(op, addr, predicted);
            outstanding_results.push_back(predicted);
            source_gap();
            if ($urandom_range(0, 49) == 0) wait_for_results();
         end
      end

      req_bus.valid <= 1'b0;
      while (outstanding_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
